### rtl/ptdc_pkg.sv
// Package for the periodic tick deadline block: field widths, register
// indexes and reset values, and the structs passed between its modules.
// No dependencies.
package ptdc_pkg;

   localparam int NOW_W      = 64;
   localparam int PERIOD_W   = 32;
   localparam int CPU_W      = 12;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_INDEX     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_TIMEKEEPER = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 32'd1000000;
   localparam logic [CPU_W-1:0]    CPU_RESET        = 12'd0;
   localparam logic                TIMEKEEPER_RESET = 1'b1;

   // Request function codes.
   localparam logic FUNC_ARM = 1'b0;

   // Saturation limit for the elapsed tick count.
   localparam longint unsigned TICK_COUNT_MAX = 65535;
   localparam logic [CNT_W-1:0] TICK_CAP =
      (TICK_COUNT_MAX > 65535) ? 16'hFFFF : 16'(TICK_COUNT_MAX);

   // Shared divider: quotient bits retired per cycle.
   localparam int DIV_STEP  = 4;
   localparam int DIV_ITERS = NOW_W / DIV_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_ITERS);

   typedef struct packed {
      logic [PERIOD_W-1:0] tick_period;
      logic [CPU_W-1:0]    cpu_index;
      logic                is_timekeeper;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [NOW_W-1:0]    dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [NOW_W-1:0]    quotient;
      logic [PERIOD_W-1:0] remainder;
   } div_rsp_type;

endpackage

### rtl/ptdc_if.sv
// Channel interfaces of the periodic tick deadline block: request, response
// and configuration write. Depends on ptdc_pkg.
interface ptdc_req_if import ptdc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [NOW_W-1:0] now;

   modport source (output valid, output func, output now, input ready);
   modport sink (input valid, input func, input now, output ready);
endinterface

interface ptdc_rsp_if import ptdc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NOW_W-1:0] compare_value;
   logic [CNT_W-1:0] ticks_elapsed;
   logic [CNT_W-1:0] wall_ticks;
   logic             early_tick;

   modport source (output valid, output compare_value, output ticks_elapsed,
                   output wall_ticks, output early_tick, input ready);
   modport sink (input valid, input compare_value, input ticks_elapsed,
                 input wall_ticks, input early_tick, output ready);
endinterface

interface ptdc_csr_if import ptdc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/periodic_tick_deadline_catchup_core.sv
// Top level of the periodic tick deadline block: sequencer, deadline state
// and response register. Depends on ptdc_pkg, ptdc_if, ptdc_csr, ptdc_div.
//
// Usage
//  req_chan carries one transaction per timer event: func selects arm or tick,
//  now is the cycle counter sampled for that event. rsp_chan returns exactly
//  one result per request: the new compare value, the elapsed tick count,
//  the wall tick count and the early flag. csr_chan writes tick_period,
//  cpu_index and is_timekeeper; it is always ready and should only be used
//  while no request is in flight.
//  Timing: one request is processed at a time. An arm passes through the
//  multiply, shift and sum states before its result is registered. A tick
//  needs no division when no period was missed and the compare value needs
//  no push; each catch-up or push that needs a division uses the shared
//  divider (4 quotient bits per cycle over 64 bits). The next request is
//  accepted once the result is registered and the sequencer is back in idle.
//  Reset: the deadline clears to zero, registers take their reset values
//  and no response is pending. If the receiver stalls, the finished result
//  waits in the response register and the next request is accepted; its
//  result then waits in the sequencer until the register is freed.
module periodic_tick_deadline_catchup_core import ptdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ptdc_req_if.sink   req_chan,
   ptdc_rsp_if.source rsp_chan,
   ptdc_csr_if.sink   csr_chan
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_ARM_MUL   = 4'd1;
   localparam logic [3:0] ST_ARM_SHIFT = 4'd2;
   localparam logic [3:0] ST_ARM_SUM   = 4'd3;
   localparam logic [3:0] ST_TICK_DIST = 4'd4;
   localparam logic [3:0] ST_TICK_DIV  = 4'd5;
   localparam logic [3:0] ST_PUSH_LIM  = 4'd6;
   localparam logic [3:0] ST_PUSH_CHK  = 4'd7;
   localparam logic [3:0] ST_PUSH_DIV  = 4'd8;
   localparam logic [3:0] ST_RESULT    = 4'd9;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [3:0]          state_ff, state_in;
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [NOW_W-1:0]    nd_ff, nd_in;
   logic [43:0]         prod_ff, prod_in;
   logic [PERIOD_W-1:0] stagger_ff, stagger_in;
   logic [NOW_W-1:0]    lim_ff, lim_in;
   logic [NOW_W-1:0]    cmp_ff, cmp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                early_ff, early_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NOW_W-1:0]    rsp_cmp_ff, rsp_cmp_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [CNT_W-1:0]    rsp_wall_ff, rsp_wall_in;
   logic                rsp_early_ff, rsp_early_in;

   logic [PERIOD_W-1:0] pe;
   logic [NOW_W-1:0]    pe_w;
   logic [3:0]          msb;
   logic [CPU_W-1:0]    cpu_low;
   logic [CPU_W-1:0]    odd;
   logic [43:0]         shifted;
   logic                req_acc;
   logic                rsp_free;

   ptdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ptdc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // A zero period behaves as a period of one.
   assign pe   = (cfg.tick_period == '0) ? PERIOD_W'(1) : cfg.tick_period;
   assign pe_w = {{(NOW_W-PERIOD_W){1'b0}}, pe};

   // Stagger: hi is the top set bit of the CPU index; the odd factor is
   // 2*(cpu-hi)+1, and dividing by 2*hi is a right shift by msb+1.
   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < CPU_W; i++) begin
         if (cfg.cpu_index[i]) begin
            msb = 4'(i);
         end
      end
   end

   assign cpu_low = cfg.cpu_index & ~(CPU_W'(1) << msb);
   assign odd     = {cpu_low[CPU_W-2:0], 1'b1};
   assign shifted = prod_ff >> (msb + 4'd1);

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      logic [NOW_W-1:0] y;
      logic [NOW_W-1:0] d;
      logic [NOW_W-1:0] k;
      state_in     = state_ff;
      now_in       = now_ff;
      nd_in        = nd_ff;
      prod_in      = prod_ff;
      stagger_in   = stagger_ff;
      lim_in       = lim_ff;
      cmp_in       = cmp_ff;
      cnt_in       = cnt_ff;
      early_in     = early_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_wall_in  = rsp_wall_ff;
      rsp_early_in = rsp_early_ff;
      div_req      = '0;
      y            = now_ff - nd_ff - pe_w;
      d            = lim_ff - nd_ff;
      k            = div_rsp.quotient + NOW_W'(2);

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               now_in   = req_chan.now;
               state_in = (req_chan.func == FUNC_ARM) ? ST_ARM_MUL : ST_TICK_DIST;
            end
         end
         ST_ARM_MUL: begin
            prod_in  = {32'd0, odd} * {12'd0, pe};
            state_in = ST_ARM_SHIFT;
         end
         ST_ARM_SHIFT: begin
            stagger_in = (cfg.cpu_index == '0) ? '0 : shifted[PERIOD_W-1:0];
            state_in   = ST_ARM_SUM;
         end
         ST_ARM_SUM: begin
            nd_in    = now_ff + pe_w + {{(NOW_W-PERIOD_W){1'b0}}, stagger_ff};
            cmp_in   = now_ff + pe_w + {{(NOW_W-PERIOD_W){1'b0}}, stagger_ff};
            cnt_in   = '0;
            early_in = 1'b0;
            state_in = ST_RESULT;
         end
         ST_TICK_DIST: begin
            // Early when now is not signed-after the deadline.
            early_in = !((nd_ff - now_ff) >= {1'b1, {(NOW_W-1){1'b0}}});
            if (y[NOW_W-1]) begin
               nd_in    = nd_ff + pe_w;
               cnt_in   = CNT_W'(1);
               state_in = ST_PUSH_LIM;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = y;
               div_req.divisor  = pe;
               state_in         = ST_TICK_DIV;
            end
         end
         ST_TICK_DIV: begin
            // k = q + 2 periods; the deadline lands on now + p - r.
            if (div_rsp.done) begin
               nd_in    = now_ff + pe_w - {{(NOW_W-PERIOD_W){1'b0}}, div_rsp.remainder};
               cnt_in   = (k > {{(NOW_W-CNT_W){1'b0}}, TICK_CAP}) ? TICK_CAP : k[CNT_W-1:0];
               state_in = ST_PUSH_LIM;
            end
         end
         ST_PUSH_LIM: begin
            lim_in   = now_ff + {{(NOW_W-PERIOD_W+1){1'b0}}, pe[PERIOD_W-1:1]};
            state_in = ST_PUSH_CHK;
         end
         ST_PUSH_CHK: begin
            if (d[NOW_W-1]) begin
               cmp_in   = nd_ff;
               state_in = ST_RESULT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = d;
               div_req.divisor  = pe;
               state_in         = ST_PUSH_DIV;
            end
         end
         ST_PUSH_DIV: begin
            if (div_rsp.done) begin
               cmp_in   = lim_ff + pe_w - {{(NOW_W-PERIOD_W){1'b0}}, div_rsp.remainder};
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cmp_in   = cmp_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_wall_in  = cfg.is_timekeeper ? cnt_ff : '0;
               rsp_early_in = early_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nd_ff        <= nd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      prod_ff      <= prod_in;
      stagger_ff   <= stagger_in;
      lim_ff       <= lim_in;
      cmp_ff       <= cmp_in;
      cnt_ff       <= cnt_in;
      early_ff     <= early_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_wall_ff  <= rsp_wall_in;
      rsp_early_ff <= rsp_early_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.compare_value = rsp_cmp_ff;
   assign rsp_chan.ticks_elapsed = rsp_cnt_ff;
   assign rsp_chan.wall_ticks    = rsp_wall_ff;
   assign rsp_chan.early_tick    = rsp_early_ff;

`ifndef SYNTHESIS
   a_early_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_early_ff |-> rsp_cnt_ff != '0)
      else $error("early tick reported with no elapsed periods");

   a_wall_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wall_ff != '0 |-> rsp_wall_ff == rsp_cnt_ff)
      else $error("wall ticks differ from elapsed ticks");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("finished result not moved to the response register");
`endif

endmodule

### rtl/ptdc_csr.sv
// Configuration registers of the periodic tick deadline block.
// Depends on ptdc_pkg and ptdc_csr_if.
module ptdc_csr import ptdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   ptdc_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_chan.index)
            CSR_TICK_PERIOD:   cfg_in.tick_period   = csr_chan.wdata[PERIOD_W-1:0];
            CSR_CPU_INDEX:     cfg_in.cpu_index     = csr_chan.wdata[CPU_W-1:0];
            CSR_IS_TIMEKEEPER: cfg_in.is_timekeeper = csr_chan.wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period   <= PERIOD_RESET;
         cfg_ff.cpu_index     <= CPU_RESET;
         cfg_ff.is_timekeeper <= TIMEKEEPER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/ptdc_div.sv
// Shared iterative divider, 64-bit dividend by 32-bit divisor, retiring
// DIV_STEP quotient bits per cycle. Depends on ptdc_pkg.
module ptdc_div import ptdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NOW_W-1:0]     quo_ff;
   logic [PERIOD_W-1:0]  rem_ff;
   logic [PERIOD_W-1:0]  div_ff;
   logic [NOW_W-1:0]     quo_in;
   logic [PERIOD_W-1:0]  rem_in;

   // Restoring division: the dividend shifts out of the top of the quotient
   // register while quotient bits shift in at the bottom.
   always_comb begin
      logic [PERIOD_W:0]   trial;
      logic [NOW_W-1:0]    quo_v;
      logic [PERIOD_W-1:0] rem_v;
      quo_v = quo_ff;
      rem_v = rem_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_v, quo_v[NOW_W-1]};
         quo_v = {quo_v[NOW_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial    = trial - {1'b0, div_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[PERIOD_W-1:0];
      end
      quo_in = quo_v;
      rem_in = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider started while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < div_ff) else $error("remainder not below divisor");
`endif

endmodule

### test/tb_periodic_tick_deadline_catchup_core.sv
// Self-checking testbench for periodic_tick_deadline_catchup_core: arm and tick
// transactions are predicted in the testbench and compared against each response.
// Depends on ptdc_pkg, ptdc_if and the core with its submodules.
module tb_periodic_tick_deadline_catchup_core import ptdc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic                 FUNC_TICK     = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;
   localparam int                   IDLE_PCT      = 19;
   localparam int                   RANDOM_ITEMS  = 1550;
   localparam int                   SETTLE_CYCLES = 60;
   localparam int unsigned          CYCLE_LIMIT   = 500000;

   typedef struct {
      logic [NOW_W-1:0] compare_value;
      logic [CNT_W-1:0] ticks_elapsed;
      logic [CNT_W-1:0] wall_ticks;
      logic             early_tick;
   } timer_reply_type;

   logic clock = 1'b0;
   logic reset;

   ptdc_req_if req_if ();
   ptdc_rsp_if rsp_if ();
   ptdc_csr_if csr_if ();

   periodic_tick_deadline_catchup_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Predicted register contents and deadline of the block.
   logic [PERIOD_W-1:0] cfg_period;
   logic [CPU_W-1:0]    cfg_cpu;
   logic                cfg_keeper;
   logic [NOW_W-1:0]    deadline;

   timer_reply_type awaited_replies[$];
   int          errors = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   bit          idle_en = 1'b1;

   always #6ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_tick_deadline_catchup_core test failed");
         $finish;
      end
   end

   // True when a lies after b on the wrapping counter.
   function automatic logic is_later(input logic [NOW_W-1:0] a, input logic [NOW_W-1:0] b);
      logic [NOW_W-1:0] diff;
      diff = b - a;
      return diff[NOW_W-1];
   endfunction

   function automatic logic [NOW_W-1:0] period_eff();
      return (cfg_period == '0) ? 64'd1 : {32'd0, cfg_period};
   endfunction

   // Works out the response to one transaction and advances the deadline.
   function automatic timer_reply_type compute_reply(input logic fn,
                                                     input logic [NOW_W-1:0] t);
      timer_reply_type  r;
      logic [NOW_W-1:0] p, hi, stagger, lag, k, cmp, half;
      logic [CNT_W-1:0] cnt;
      p = period_eff();
      if (fn == FUNC_ARM) begin
         stagger = '0;
         if (cfg_cpu != '0) begin
            hi = 64'd1;
            while ((hi << 1) <= {52'd0, cfg_cpu})
               hi = hi << 1;
            stagger = ((64'd2 * ({52'd0, cfg_cpu} - hi) + 64'd1) * p) / hi / 64'd2;
         end
         deadline = t + p + stagger;
         r.compare_value = deadline;
         r.ticks_elapsed = '0;
         r.wall_ticks    = '0;
         r.early_tick    = 1'b0;
      end else begin
         r.early_tick = !is_later(t, deadline);
         lag = t - deadline - p;
         k = lag[NOW_W-1] ? 64'd1 : lag / p + 64'd2;
         cnt = (k > {48'd0, TICK_CAP}) ? TICK_CAP : k[CNT_W-1:0];
         deadline = deadline + k * p;
         // The compare value is pushed clear of now by at least half a period.
         half = t + p / 64'd2;
         cmp = deadline;
         if (!is_later(cmp, half))
            cmp = cmp + ((half - cmp) / p + 64'd1) * p;
         r.compare_value = cmp;
         r.ticks_elapsed = cnt;
         r.wall_ticks    = cfg_keeper ? cnt : '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [NOW_W-1:0] got,
                                  input logic [NOW_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   // The request valid stays high between back-to-back transactions; it is only
   // lowered for an idle gap or when draining.
   task automatic send_item(input logic fn, input logic [NOW_W-1:0] t);
      if (idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= fn;
      req_if.now   <= t;
      do @(posedge clock); while (!req_if.ready);
      awaited_replies.push_back(compute_reply(fn, t));
      items_sent++;
   endtask

   task automatic drain_replies();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_TICK_PERIOD:   cfg_period = data;
         CSR_CPU_INDEX:     cfg_cpu    = data[CPU_W-1:0];
         CSR_IS_TIMEKEEPER: cfg_keeper = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] period_w,
                                input logic [CSR_DATA_W-1:0] cpu_w,
                                input logic [CSR_DATA_W-1:0] keeper_w);
      drain_replies();
      if ($urandom_range(3) == 0)
         write_register(CSR_SPARE, $urandom);
      write_register(CSR_TICK_PERIOD, period_w);
      write_register(CSR_CPU_INDEX, cpu_w);
      write_register(CSR_IS_TIMEKEEPER, keeper_w);
      csr_if.valid <= 1'b0;
   endtask

   // Response checker and receiver back-pressure.
   always @(posedge clock) begin
      timer_reply_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected response", rsp_if.compare_value, '0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_if.compare_value !== want.compare_value)
                  report_mismatch("compare_value", rsp_if.compare_value, want.compare_value);
               if (rsp_if.ticks_elapsed !== want.ticks_elapsed)
                  report_mismatch("ticks_elapsed", rsp_if.ticks_elapsed, want.ticks_elapsed);
               if (rsp_if.wall_ticks !== want.wall_ticks)
                  report_mismatch("wall_ticks", rsp_if.wall_ticks, want.wall_ticks);
               if (rsp_if.early_tick !== want.early_tick)
                  report_mismatch("early_tick", rsp_if.early_tick, want.early_tick);
            end
         end
         rsp_if.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Runs on the register values left by reset.
   task automatic test_reset_values();
      send_item(FUNC_TICK, '0);
      send_item(FUNC_ARM, '0);
      // A tick landing exactly on the deadline still counts as early.
      send_item(FUNC_TICK, deadline);
      send_item(FUNC_TICK, deadline + 1);
      send_item(FUNC_TICK, deadline - 1);
      send_item(FUNC_TICK, deadline + 3 * period_eff() - 10);
      send_item(FUNC_ARM, '1);
      send_item(FUNC_TICK, deadline + 5);
      send_item(FUNC_TICK, deadline + 64'h8000_0000_0000_0000);
   endtask

   task automatic test_arm_stagger();
      int unsigned cpus[7];
      cpus = '{1, 2, 3, 5, 2048, 2049, 4095};
      for (int i = 0; i < 7; i++) begin
         apply_setting((i % 2 == 1) ? $urandom : 32'hFFFF_FFFF,
                       {20'($urandom), 12'(cpus[i])}, $urandom);
         send_item(FUNC_ARM, {$urandom, $urandom});
      end
   endtask

   task automatic test_tick_corners();
      // A zero period behaves as a period of one; wall ticks are withheld here.
      apply_setting('0, '0, '0);
      send_item(FUNC_ARM, {$urandom, $urandom});
      send_item(FUNC_TICK, deadline);
      send_item(FUNC_TICK, deadline + 10);
      apply_setting(32'd1, 32'd0, 32'd1);
      send_item(FUNC_ARM, '0);
      send_item(FUNC_TICK, deadline + 70000);
      apply_setting('1, 32'd7, 32'd1);
      send_item(FUNC_ARM, 64'hFFFF_FFFF_0000_0000);
      send_item(FUNC_TICK, deadline + 64'd40000 * 64'hFFFF_FFFF - 3);
      send_item(FUNC_TICK, deadline + 64'd70000 * 64'hFFFF_FFFF);
   endtask

   // Phases of arm-then-ticks sequences under random settings, with some noise.
   task automatic test_random_traffic();
      int unsigned         target, phase_end, phase;
      logic [CSR_DATA_W-1:0] per_w, cpu_w;
      logic [NOW_W-1:0]    p, t;
      logic [31:0]         pw;
      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         idle_en = (phase != 5) && (phase != 6);
         case ($urandom_range(9))
            0:       per_w = '0;
            1:       per_w = 32'd1;
            2:       per_w = '1;
            3:       per_w = PERIOD_RESET;
            4, 5:    per_w = $urandom_range(2, 64);
            6, 7:    per_w = $urandom_range(65, 100000);
            default: per_w = $urandom;
         endcase
         cpu_w = $urandom;
         case ($urandom_range(3))
            0:       cpu_w[CPU_W-1:0] = '0;
            1:       cpu_w[CPU_W-1:0] = '1;
            2:       cpu_w[CPU_W-1:0] = CPU_W'(1) << $urandom_range(0, CPU_W - 1);
            default: ;
         endcase
         apply_setting(per_w, cpu_w, $urandom);
         phase_end = items_sent + $urandom_range(40, 120);
         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 8) begin
               send_item(1'($urandom_range(1)), {$urandom, $urandom});
            end else begin
               case ($urandom_range(3))
                  0:       t = '0;
                  1:       t = '1 - $urandom_range(0, 2000000);
                  default: t = {$urandom, $urandom};
               endcase
               send_item(FUNC_ARM, t);
               repeat ($urandom_range(1, 10)) begin
                  p = period_eff();
                  pw = p[31:0];
                  case ($urandom_range(11))
                     0: t = deadline - $urandom_range(0, (pw > 1000) ? 1000 : pw);
                     1: t = deadline;
                     2: t = deadline + $urandom_range(1, pw);
                     3: t = deadline + $urandom_range(1, 5) * p + $urandom_range(0, pw - 1);
                     // Just short of a later deadline, so the compare value is pushed.
                     4: t = deadline + $urandom_range(1, 3) * p
                            - $urandom_range(1, (pw > 1) ? pw / 2 : 1);
                     5: t = deadline + (64'd65535 + $urandom_range(0, 3)) * p
                            + $urandom_range(0, 1);
                     6: t = deadline + ({$urandom, $urandom} >> $urandom_range(1, 63));
                     7: t = {$urandom, $urandom};
                     default: t = deadline + $urandom_range(0, pw / 8);
                  endcase
                  send_item(FUNC_TICK, t);
               end
            end
         end
         phase++;
      end
      idle_en = 1'b1;
   endtask

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_ARM;
      req_if.now   <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_TICK_PERIOD;
      csr_if.wdata <= '0;
      cfg_period = PERIOD_RESET;
      cfg_cpu    = CPU_RESET;
      cfg_keeper = TIMEKEEPER_RESET;
      deadline   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_arm_stagger();
      test_tick_corners();
      test_random_traffic();

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("periodic_tick_deadline_catchup_core test passed");
      else
         $display("periodic_tick_deadline_catchup_core test failed");
      $finish;
   end

endmodule
